// ----- rtl/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// sha512_pkg
// Round constants, initial hash values and round functions for SHA-512.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkWords = 16;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

endpackage

// ----- rtl/sha512_stream_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// sha512_stream_hasher_unit
// SHA-512 hasher over a byte stream of up to eight bytes per item.
// ----------------------------------------------------------------------------
// Each input item is taken in the idle state, loaded byte by byte and then
// closed. Every completed 128-byte block runs 80 passes of the single shared
// round unit and then folds the working words into the chaining value. An
// item that closes a message also pads byte by byte (including the length),
// runs one or two compressions and then offers eight digest words, one per
// cycle while out_stall is low. The message schedule is kept as a
// sixteen-word sliding window. in_stall is high whenever an item is being
// worked on.
module sha512_stream_hasher_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sha512_pkg::word_t         in_data_word,
  input  logic [3:0]                in_byte_count,
  input  logic                      in_end_of_message,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sha512_pkg::word_t         out_digest_word,
  output logic [2:0]                out_word_index,
  output logic                      out_last_word
);
  import sha512_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]   state_r, state_nxt;
  word_t        h_r [8];
  word_t        v_r [8];
  word_t        w_r [BlkWords];
  logic [6:0]   fill_r;
  logic [127:0] len_r;
  logic [63:0]  data_r;
  logic [3:0]   cnt_r;
  logic         fin_r;
  logic         padding_r;
  logic         tail_r;
  logic [6:0]   rnd_r;
  logic [2:0]   oidx_r;
  logic [127:0] pad_len_r;

  logic [3:0]   cnt_in;
  logic         byte_go;
  logic [7:0]   byte_val;
  logic         acc_in;
  word_t        wt, t1, t2, wnew;

  assign cnt_in  = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
  assign acc_in  = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle);

  always_comb begin
    byte_go  = 1'b0;
    byte_val = 8'h00;
    if (state_r == StLoad && cnt_r != 4'd0) begin
      byte_go  = 1'b1;
      byte_val = data_r[63:56];
    end else if (state_r == StPad) begin
      byte_go = 1'b1;
      if (!padding_r)
        byte_val = 8'h80;
      else if (tail_r && fill_r >= 7'd112)
        byte_val = pad_len_r[127:120];
      else
        byte_val = 8'h00;
    end
  end

  assign wt   = w_r[0];
  assign t1   = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + RoundK[rnd_r] + wt;
  assign t2   = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign wnew = sig1(w_r[14]) + w_r[9] + sig0(w_r[1]) + w_r[0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StIdle:  if (acc_in) state_nxt = StLoad;
      StLoad: begin
        if (cnt_r == 4'd0)
          state_nxt = fin_r ? StPad : StIdle;
        else if (fill_r == 7'd127)
          state_nxt = StRound;
      end
      StRound: if (rnd_r == 7'd79) state_nxt = StFold;
      StFold: begin
        if (cnt_r != 4'd0)
          state_nxt = StLoad;
        else if (fin_r && padding_r && tail_r)
          state_nxt = StOut;
        else if (fin_r)
          state_nxt = StPad;
        else
          state_nxt = StIdle;
      end
      StPad: if (fill_r == 7'd127) state_nxt = StRound;
      StOut: if (!out_stall && oidx_r == 3'd7) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StIdle;
      fill_r    <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      fin_r     <= 1'b0;
      padding_r <= 1'b0;
      tail_r    <= 1'b0;
      rnd_r     <= '0;
      oidx_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
    end else begin
      state_r <= state_nxt;
      case (state_r)
        StIdle: begin
          if (acc_in) begin
            data_r <= in_data_word;
            cnt_r  <= cnt_in;
            fin_r  <= in_end_of_message;
            len_r  <= len_r + {121'd0, cnt_in, 3'd0};
          end
        end
        StLoad, StPad: begin
          if (byte_go) begin
            w_r[fill_r[6:3]] <= {w_r[fill_r[6:3]][55:0], byte_val};
            fill_r <= fill_r + 7'd1;
            if (state_r == StLoad) begin
              data_r <= {data_r[55:0], 8'h00};
              cnt_r  <= cnt_r - 4'd1;
            end else if (!padding_r) begin
              padding_r <= 1'b1;
              pad_len_r <= len_r;
              tail_r    <= (fill_r < 7'd112);
            end else if (tail_r && fill_r >= 7'd112) begin
              pad_len_r <= {pad_len_r[119:0], 8'h00};
            end
            if (fill_r == 7'd127) begin
              rnd_r <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            end
          end
        end
        StRound: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
          w_r[BlkWords-1] <= wnew;
          rnd_r <= rnd_r + 7'd1;
        end
        StFold: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          oidx_r <= '0;
          if (fin_r && padding_r && !tail_r)
            tail_r <= 1'b1;
        end
        StOut: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
              len_r     <= '0;
              fill_r    <= '0;
              padding_r <= 1'b0;
              tail_r    <= 1'b0;
              fin_r     <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = (state_r == StOut);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> in_stall)
    else $error("input taken while busy");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (state_r == StIdle && fill_r == 7'd0))
    else $error("state not cleared after digest");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StRound) |-> (rnd_r < 7'd80))
    else $error("round count overrun");
`endif

endmodule

// ----- verif/sha512_stream_hasher_unit_test.sv -----
// ----------------------------------------------------------------------------
// sha512_stream_hasher_unit_test
// Streams messages of random and boundary lengths into the SHA-512 hasher
// and checks each digest word it emits against a behavioural SHA-512 model
// kept in step with the accepted items.
// ----------------------------------------------------------------------------
module sha512_stream_hasher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;

  typedef struct packed {
    word_t      data;
    logic [3:0] nbytes;
    logic       eom;
  } msg_item_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  word_t      in_data_word = '0;
  logic [3:0] in_byte_count = '0;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  word_t      out_digest_word;
  logic [2:0] out_word_index;
  logic       out_last_word;

  sha512_stream_hasher_unit i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  msg_item_t    pending_items[$];
  digest_item_t expected_digests[$];
  int           send_idle_pct = 6;
  int           recv_idle_pct = 72;
  int           hold_off_cycles = 0;
  int           errors = 0;

  // hash state mirror
  word_t     hash_h[8];
  logic [7:0] blk_bytes[128];
  int        blk_fill;
  logic [127:0] msg_bits;

  function automatic void hash_init();
    for (int i = 0; i < 8; i++) hash_h[i] = InitH[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic word_t rr(word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void compress_block();
    word_t w[80];
    word_t v[8];
    word_t t1, t2;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], blk_bytes[i*8+j]};
    for (int i = 16; i < 80; i++)
      w[i] = (rr(w[i-2], 19) ^ rr(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
           + (rr(w[i-15], 1) ^ rr(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 128) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void hash_item(msg_item_t it);
    int n;
    logic [127:0] len;
    digest_item_t d;
    n = (it.nbytes > 8) ? 8 : it.nbytes;
    msg_bits += 128'(n * 8);
    for (int i = 0; i < n; i++) absorb_byte(it.data[63-8*i -: 8]);
    if (it.eom) begin
      len = msg_bits;
      absorb_byte(8'h80);
      while (blk_fill != 112) absorb_byte(8'h00);
      for (int k = 15; k >= 0; k--) absorb_byte(len[k*8 +: 8]);
      for (int k = 0; k < 8; k++) begin
        d.word = hash_h[k];
        d.idx  = 3'(k);
        d.last = (k == 7);
        expected_digests = {expected_digests, d};
      end
      hash_init();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    msg_item_t it;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        hash_item('{in_data_word, in_byte_count, in_end_of_message});
        void'(pending_items.pop_front());
      end
      if ((!in_valid || !in_stall) && pending_items.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        it = pending_items[0];
        in_valid          <= 1'b1;
        in_data_word      <= it.data;
        in_byte_count     <= it.nbytes;
        in_end_of_message <= it.eom;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          errors++;
        end else begin
          e = expected_digests.pop_front();
          if (out_digest_word !== e.word) begin
            $error("digest_word exp %h got %h", e.word, out_digest_word);
            errors++;
          end
          if (out_word_index !== e.idx) begin
            $error("word_index exp %0d got %0d", e.idx, out_word_index);
            errors++;
          end
          if (out_last_word !== e.last) begin
            $error("last_word exp %0d got %0d", e.last, out_last_word);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic void add_item(word_t d, int n, bit eom);
    msg_item_t it;
    it.data = d;
    it.nbytes = 4'(n);
    it.eom = eom;
    pending_items = {pending_items, it};
  endfunction

  function automatic void add_message(int nbytes_total);
    int left;
    int n;
    left = nbytes_total;
    while (left > 0) begin
      n = (left >= 8) ? 8 : left;
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      left -= n;
      add_item({$urandom, $urandom}, n, left == 0);
    end
    if (nbytes_total == 0) add_item({$urandom, $urandom}, 0, 1);
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_digests.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int sent;
    hash_init();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // empty message, extremes, oversize counts, zero count without end flag
    add_item('0, 0, 1);
    add_item('1, 8, 0);
    add_item('0, 0, 0);
    add_item('1, 15, 0);
    add_item(64'h0123456789abcdef, 9, 0);
    add_item({$urandom, $urandom}, 1, 1);
    add_item('0, 8, 0);
    add_item('1, 3, 1);
    for (int i = 0; i < 14; i++) add_item('1, 8, i == 13);
    add_item(64'haaaa5555aaaa5555, 7, 1);
    // long receiver hold-off while the sender keeps offering
    hold_off_cycles = 3000;
    add_message(300);
    drain();
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 6 : 0;
      sent = 0;
      while (sent < 85) begin
        case ($urandom_range(5))
          0: add_message($urandom_range(100, 260));
          1: add_message($urandom_range(110, 113));
          default: add_message($urandom_range(0, 40));
        endcase
        if ($urandom_range(7) == 0) add_item({$urandom, $urandom}, 0, 0);
        sent = pending_items.size() + sent;
        drain();
      end
    end
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sha512_pkg.sv
rtl/sha512_stream_hasher_unit.sv
verif/sha512_stream_hasher_unit_test.sv
